/* hw/rtl/gas_sensor_reply_checker_assert.svh */
// Assertion macros for the sensor reply checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef GAS_SENSOR_REPLY_CHECKER_ASSERT_SVH
`define GAS_SENSOR_REPLY_CHECKER_ASSERT_SVH

// same-cycle implication
`define GSRC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define GSRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/gsrc_pkg.sv */
// Shared types and constants of the sensor reply checker.
// No dependencies.
`default_nettype none

package gsrc_pkg;

    localparam int FRAME_BYTES = 7;
    localparam int POS_W       = 3;
    localparam int SUM_W       = 11;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    localparam logic [7:0] MIN_RAW  = 8'd13;
    localparam logic [7:0] CHK_BASE = 8'hFF;

    // scaling: q = ((d - 13) * factor + 114) / 229, division by reciprocal
    localparam int          X_W         = 23;
    localparam int          PROD_W      = 55;
    localparam int          RECIP_SHIFT = 39;
    localparam logic [22:0] VOC_FACTOR  = 23'd16000;
    localparam logic [22:0] CO2_FACTOR  = 23'd25600;
    localparam logic [22:0] ROUND_BIAS  = 23'd114;
    localparam logic [31:0] RECIP_M     = 32'd2400680410;
    localparam logic [15:0] CO2_OFFSET  = 16'd6400;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_DATA  = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_CHIP_ERR = 3'd3,
        ST_BOGUS    = 3'd4
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] err;
    } reply_rec_t;

    typedef struct packed {
        logic       valid;
        reply_rec_t rec;
    } q_push_t;

endpackage

`default_nettype wire

/* hw/rtl/gsrc_front.sv */
// Front end: takes reply bytes, accumulates the frame and classifies it.
// Uses gsrc_pkg; pushes one record per completed reply into the queue.
`default_nettype none

module gsrc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_start,
    input  wire logic          q_full,
    output gsrc_pkg::q_push_t  push
);
    import gsrc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             az_reg, az_next;
    logic [7:0]       d1_reg, d1_next;
    logic [7:0]       d2_reg, d2_next;
    logic [7:0]       err_reg, err_next;

    logic [POS_W-1:0] eff_pos;
    logic [SUM_W-1:0] eff_sum;
    logic [SUM_W-1:0] fold_sum;
    logic [7:0]       expected;
    logic             az_now;
    logic             last;
    logic             accept;
    status_t          status;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;

    always_comb
    begin
        // a start mark drops any partial reply
        eff_pos  = frame_start ? '0 : pos_reg;
        eff_sum  = frame_start ? '0 : sum_reg;
        az_now   = (frame_start | az_reg) & (rx_byte == 8'd0);
        last     = (eff_pos == POS_W'(FRAME_BYTES - 1));
        fold_sum = eff_sum + {{(SUM_W-3){1'b0}}, eff_sum[SUM_W-1:8]};
        expected = CHK_BASE - fold_sum[7:0];

        if (az_now)
            status = ST_NO_DATA;
        else if (rx_byte != expected)
            status = ST_CHECKSUM;
        else if (err_reg != 8'd0)
            status = ST_CHIP_ERR;
        else if ((d1_reg < MIN_RAW) || (d2_reg < MIN_RAW))
            status = ST_BOGUS;
        else
            status = ST_OK;
    end

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        az_next  = az_reg;
        d1_next  = d1_reg;
        d2_next  = d2_reg;
        err_next = err_reg;
        if (accept)
        begin
            if (last)
            begin
                pos_next = '0;
                sum_next = '0;
                az_next  = 1'b1;
            end
            else
            begin
                pos_next = eff_pos + POS_W'(1);
                sum_next = eff_sum + SUM_W'(rx_byte);
                az_next  = az_now;
                if (eff_pos == POS_W'(0))
                    d1_next = rx_byte;
                else if (eff_pos == POS_W'(1))
                    d2_next = rx_byte;
                else if (eff_pos == POS_W'(FRAME_BYTES - 2))
                    err_next = rx_byte;
            end
        end
    end

    always_comb
    begin
        push.valid      = accept & last;
        push.rec.status = status;
        push.rec.d1     = d1_reg;
        push.rec.d2     = d2_reg;
        push.rec.err    = err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
            az_reg  <= 1'b1;
            d1_reg  <= '0;
            d2_reg  <= '0;
            err_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            az_reg  <= az_next;
            d1_reg  <= d1_next;
            d2_reg  <= d2_next;
            err_reg <= err_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/gsrc_queue.sv */
// Short queue of classified reply records between front and back end.
// Uses gsrc_pkg.
`default_nettype none

module gsrc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gsrc_pkg::q_push_t push,
    input  wire logic           pop,
    output gsrc_pkg::reply_rec_t head,
    output logic                empty,
    output logic                full
);
    import gsrc_pkg::*;

    reply_rec_t         mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (cnt_reg == Q_CNT_W'(0));
    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign do_push = push.valid & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/gsrc_back.sv */
// Back end: scales the raw readings to Q4 and holds the result register.
// Uses gsrc_pkg; two stages, constant multiply then reciprocal divide by 229.
`default_nettype none

module gsrc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gsrc_pkg::reply_rec_t head,
    input  wire logic                 q_empty,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output gsrc_pkg::status_t         status,
    output logic [14:0]               voc_ppb_q4,
    output logic [15:0]               co2_ppm_q4,
    output logic [7:0]                chip_error
);
    import gsrc_pkg::*;

    logic             s1_valid_reg;
    status_t          s1_status_reg;
    logic [7:0]       s1_err_reg;
    logic [X_W-1:0]   s1_voc_x_reg;
    logic [X_W-1:0]   s1_co2_x_reg;

    logic             out_valid_reg;
    status_t          status_reg;
    logic [14:0]      voc_reg;
    logic [15:0]      co2_reg;
    logic [7:0]       err_reg;

    logic             s2_load;
    logic             s1_load;
    logic [7:0]       voc_diff;
    logic [7:0]       co2_diff;
    logic [X_W-1:0]   voc_x;
    logic [X_W-1:0]   co2_x;
    logic [PROD_W-1:0] voc_prod;
    logic [PROD_W-1:0] co2_prod;
    logic [14:0]      voc_q;
    logic [15:0]      co2_q;

    assign s2_load = ~out_valid_reg | ~out_stall;
    assign s1_load = ~s1_valid_reg | s2_load;
    assign pop     = s1_load & ~q_empty;

    always_comb
    begin
        // the difference wraps for a bogus reading; such results are zeroed
        voc_diff = head.d1 - MIN_RAW;
        co2_diff = head.d2 - MIN_RAW;
        voc_x    = X_W'(voc_diff) * VOC_FACTOR + ROUND_BIAS;
        co2_x    = X_W'(co2_diff) * CO2_FACTOR + ROUND_BIAS;
        voc_prod = PROD_W'(s1_voc_x_reg) * PROD_W'(RECIP_M);
        co2_prod = PROD_W'(s1_co2_x_reg) * PROD_W'(RECIP_M);
        voc_q    = voc_prod[RECIP_SHIFT+14:RECIP_SHIFT];
        co2_q    = co2_prod[RECIP_SHIFT+15:RECIP_SHIFT] + CO2_OFFSET;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_status_reg <= head.status;
            s1_err_reg    <= head.err;
            s1_voc_x_reg  <= voc_x;
            s1_co2_x_reg  <= co2_x;
        end
        if (s2_load && s1_valid_reg)
        begin
            status_reg <= s1_status_reg;
            err_reg    <= s1_err_reg;
            voc_reg    <= (s1_status_reg == ST_OK) ? voc_q : '0;
            co2_reg    <= (s1_status_reg == ST_OK) ? co2_q : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= ~q_empty;
            if (s2_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign voc_ppb_q4 = voc_reg;
    assign co2_ppm_q4 = co2_reg;
    assign chip_error = err_reg;

endmodule

`default_nettype wire

/* hw/rtl/gas_sensor_reply_checker.sv */
// Sensor reply checker: one reply byte per cycle unless stalled, a result per 7 bytes.
// A reply's record passes the queue, the multiply register, then the result register.
// Input: one byte per cycle while in_stall is low; the front end stalls only while the
// four-entry record queue is full, so a stalled output stops input after six replies.
// Reset (rst_n, asynchronous): position, sum and queue clear; no result pending.
`default_nettype none

module gas_sensor_reply_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [14:0]      voc_ppb_q4,
    output logic [15:0]      co2_ppm_q4,
    output logic [7:0]       chip_error
);
    import gsrc_pkg::*;

    `include "gas_sensor_reply_checker_assert.svh"

    q_push_t    q_push;
    reply_rec_t q_head;
    logic       q_empty;
    logic       q_full;
    logic       q_pop;
    status_t    res_status;

    gsrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .q_full      (q_full),
        .push        (q_push)
    );

    gsrc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty),
        .full  (q_full)
    );

    gsrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_empty    (q_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (res_status),
        .voc_ppb_q4 (voc_ppb_q4),
        .co2_ppm_q4 (co2_ppm_q4),
        .chip_error (chip_error)
    );

    assign status = res_status;

    `GSRC_ASSERT_SAME(a_pop_not_empty, q_pop, !q_empty)
    `GSRC_ASSERT_SAME(a_push_has_room, q_push.valid, !q_full)
    `GSRC_ASSERT_SAME(a_non_ok_zero, out_valid && (res_status != ST_OK),
        (voc_ppb_q4 == 15'd0) && (co2_ppm_q4 == 16'd0))
    `GSRC_ASSERT_SAME(a_ok_co2_floor, out_valid && (res_status == ST_OK),
        co2_ppm_q4 >= CO2_OFFSET)

endmodule

`default_nettype wire
